// ===== src/script_token_scanner_unit_assert.svh =====
// Assertion macros for the token scanner unit.
// Included by the modules that check their own logic; no other dependencies.
`ifndef SCRIPT_TOKEN_SCANNER_UNIT_ASSERT_SVH
`define SCRIPT_TOKEN_SCANNER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Check a boolean at every clock edge outside reset
`define STS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that an antecedent implies a consequent in the same cycle
`define STS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define STS_ASSERT(lbl, clk, rst_n, prop, msg)
`define STS_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== src/sts_pkg.sv =====
// Shared types, token codes, keyword table and character classes for the
// token scanner unit. No dependencies.
package sts_pkg;

  localparam int KEYWORD_MAX_LEN = 8;
  localparam int KEYWORD_COUNT   = 22;
  localparam int QDEPTH          = 4;
  localparam int QAW             = 2;

  // Token kinds on close records
  localparam logic [5:0] K_EOF          = 6'd0;
  localparam logic [5:0] K_ERROR        = 6'd1;
  localparam logic [5:0] K_NUMBER       = 6'd2;
  localparam logic [5:0] K_IDENT        = 6'd3;
  localparam logic [5:0] K_STRING       = 6'd4;
  localparam logic [5:0] K_PLUS         = 6'd5;
  localparam logic [5:0] K_MINUS        = 6'd6;
  localparam logic [5:0] K_MULT         = 6'd7;
  localparam logic [5:0] K_DIV          = 6'd8;
  localparam logic [5:0] K_LPAREN       = 6'd9;
  localparam logic [5:0] K_RPAREN       = 6'd10;
  localparam logic [5:0] K_ASSIGN       = 6'd11;
  localparam logic [5:0] K_EQ           = 6'd12;
  localparam logic [5:0] K_KEYWORD_BASE = 6'd13;

  // Record kinds
  localparam logic REC_BYTE  = 1'b0;
  localparam logic REC_CLOSE = 1'b1;

  // Characters with a role of their own
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_CR      = 8'h0D;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5C;
  localparam logic [7:0] CH_UNDER   = 8'h5F;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_EQUALS  = 8'h3D;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_SLASH   = 8'h2F;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_LOW_N   = 8'h6E;
  localparam logic [7:0] CH_LOW_T   = 8'h74;
  localparam logic [7:0] CH_LOW_R   = 8'h72;

  // Keywords, first byte in the lowest bits
  localparam logic [63:0] KW_TABLE [KEYWORD_COUNT] = '{
    64'h0000_0000_0064_6e61,  // and
    64'h0000_006b_6165_7262,  // break
    64'h0000_0000_0000_6f64,  // do
    64'h0000_0000_6573_6c65,  // else
    64'h0000_6669_6573_6c65,  // elseif
    64'h0000_0000_0064_6e65,  // end
    64'h0000_0065_736c_6166,  // false
    64'h0000_0000_0072_6f66,  // for
    64'h6e6f_6974_636e_7566,  // function
    64'h0000_0000_0000_6669,  // if
    64'h0000_0000_0000_6e69,  // in
    64'h0000_006c_6163_6f6c,  // local
    64'h0000_0000_006c_696e,  // nil
    64'h0000_0000_0074_6f6e,  // not
    64'h0000_0000_0000_726f,  // or
    64'h0000_7461_6570_6572,  // repeat
    64'h0000_6e72_7574_6572,  // return
    64'h0000_0000_6e65_6874,  // then
    64'h0000_0000_6575_7274,  // true
    64'h0000_006c_6974_6e75,  // until
    64'h0000_0065_6c69_6877,  // while
    64'h0000_0074_6e69_7270   // print
  };

  // One result record
  typedef struct packed {
    logic        last;
    logic        rec_kind;
    logic [7:0]  lex_byte;
    logic [5:0]  token_kind;
    logic [15:0] tok_line;
    logic [15:0] tok_column;
    logic [15:0] tok_length;
  } rec_t;

  // Records produced by one accepted word
  typedef struct packed {
    logic [1:0]      cnt;
    rec_t [2:0]      recs;
  } push_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  // Keyword lookup on the identifier prefix; a long identifier is plain
  function automatic logic [5:0] ident_kind(input logic [63:0] pfx, input logic [3:0] wlen);
    logic [5:0] k;
    k = K_IDENT;
    if (wlen <= 4'(KEYWORD_MAX_LEN)) begin
      for (int i = 0; i < KEYWORD_COUNT; i++) begin
        if (pfx == KW_TABLE[i]) k = K_KEYWORD_BASE + 6'(i);
      end
    end
    return k;
  endfunction

endpackage

// ===== src/sts_core.sv =====
// Scanner state and the combinational step that turns one input word into up
// to three result records. Depends on sts_pkg.
module sts_core #(
  parameter int POS_WIDTH = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     ch_i,
  input  logic           eoi_i,
  output sts_pkg::push_t push_o
);
  import sts_pkg::*;

  localparam logic [2:0] M_IDLE   = 3'd0;
  localparam logic [2:0] M_NUMBER = 3'd1;
  localparam logic [2:0] M_IDENT  = 3'd2;
  localparam logic [2:0] M_STRING = 3'd3;
  localparam logic [2:0] M_ESCAPE = 3'd4;
  localparam logic [2:0] M_ASSIGN = 3'd5;

  logic [2:0]           mode_q, mode_d;
  logic [63:0]          pfx_q, pfx_d;
  logic [3:0]           wlen_q, wlen_d;
  logic [15:0]          tbytes_q, tbytes_d;
  logic [POS_WIDTH-1:0] line_q, line_d, col_q, col_d;
  logic [POS_WIDTH-1:0] sline_q, sline_d, scol_q, scol_d;
  rec_t [2:0]           recs;
  logic [1:0]           n_rec;
  logic                 do_idle;
  logic [5:0]           op_kind;
  logic [7:0]           esc_byte;

  function automatic logic [15:0] sat_out(input logic [POS_WIDTH-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    return (w > 32'h0000_FFFF) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic rec_t mk_rec(input logic rk, input logic [7:0] b, input logic [5:0] tk,
                                  input logic [POS_WIDTH-1:0] ln,
                                  input logic [POS_WIDTH-1:0] cl, input logic [15:0] len);
    rec_t r;
    r.last       = 1'b0;
    r.rec_kind   = rk;
    r.lex_byte   = b;
    r.token_kind = tk;
    r.tok_line   = sat_out(ln);
    r.tok_column = sat_out(cl);
    r.tok_length = len;
    return r;
  endfunction

  // Step the scanner for one word
  always_comb begin
    mode_d   = mode_q;
    pfx_d    = pfx_q;
    wlen_d   = wlen_q;
    tbytes_d = tbytes_q;
    line_d   = line_q;
    col_d    = col_q;
    sline_d  = sline_q;
    scol_d   = scol_q;
    recs     = '0;
    n_rec    = 2'd0;
    do_idle  = 1'b0;
    op_kind  = K_ERROR;
    esc_byte = ch_i;

    if (eoi_i) begin
      // Close any pending token, then report end of input
      case (mode_q)
        M_NUMBER: begin
          recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, K_NUMBER, sline_d, scol_d, tbytes_d);
          n_rec = n_rec + 2'd1;
        end
        M_IDENT: begin
          recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, ident_kind(pfx_q, wlen_q), sline_d, scol_d,
                               tbytes_d);
          n_rec = n_rec + 2'd1;
        end
        M_STRING, M_ESCAPE: begin
          recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, K_STRING, sline_d, scol_d, tbytes_d);
          n_rec = n_rec + 2'd1;
        end
        M_ASSIGN: begin
          recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, K_ASSIGN, sline_d, scol_d, tbytes_d);
          n_rec = n_rec + 2'd1;
        end
        default: ;
      endcase
      mode_d = M_IDLE;
      recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, K_EOF, line_d, col_d, 16'h0000);
      n_rec = n_rec + 2'd1;
    end else begin
      case (mode_q)
        M_NUMBER: begin
          if (is_digit(ch_i) || (ch_i == CH_DOT)) begin
            if (tbytes_d != 16'hFFFF) tbytes_d = tbytes_d + 16'd1;
            recs[n_rec] = mk_rec(REC_BYTE, ch_i, K_EOF, sline_d, scol_d, tbytes_d);
            n_rec = n_rec + 2'd1;
            if (col_d != '1) col_d = col_d + 1'b1;
          end else begin
            recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, K_NUMBER, sline_d, scol_d, tbytes_d);
            n_rec = n_rec + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_IDENT: begin
          if (is_alpha(ch_i) || is_digit(ch_i) || (ch_i == CH_UNDER)) begin
            if (wlen_d < 4'(KEYWORD_MAX_LEN)) pfx_d[{wlen_d[2:0], 3'b000} +: 8] = ch_i;
            if (wlen_d <= 4'(KEYWORD_MAX_LEN)) wlen_d = wlen_d + 4'd1;
            if (tbytes_d != 16'hFFFF) tbytes_d = tbytes_d + 16'd1;
            recs[n_rec] = mk_rec(REC_BYTE, ch_i, K_EOF, sline_d, scol_d, tbytes_d);
            n_rec = n_rec + 2'd1;
            if (col_d != '1) col_d = col_d + 1'b1;
          end else begin
            recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, ident_kind(pfx_q, wlen_q), sline_d, scol_d,
                                 tbytes_d);
            n_rec = n_rec + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_ASSIGN: begin
          if (ch_i == CH_EQUALS) begin
            if (tbytes_d != 16'hFFFF) tbytes_d = tbytes_d + 16'd1;
            recs[n_rec] = mk_rec(REC_BYTE, ch_i, K_EOF, sline_d, scol_d, tbytes_d);
            n_rec = n_rec + 2'd1;
            recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, K_EQ, sline_d, scol_d, tbytes_d);
            n_rec = n_rec + 2'd1;
            if (col_d != '1) col_d = col_d + 1'b1;
            mode_d = M_IDLE;
          end else begin
            recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, K_ASSIGN, sline_d, scol_d, tbytes_d);
            n_rec = n_rec + 2'd1;
            do_idle = 1'b1;
          end
        end
        M_STRING: begin
          if (ch_i == CH_NEWLINE) begin
            if (line_d != '1) line_d = line_d + 1'b1;
            col_d = POS_WIDTH'(1);
          end else if (col_d != '1) begin
            col_d = col_d + 1'b1;
          end
          if (ch_i == CH_QUOTE) begin
            recs[n_rec] = mk_rec(REC_CLOSE, 8'h00, K_STRING, sline_d, scol_d, tbytes_d);
            n_rec = n_rec + 2'd1;
            mode_d = M_IDLE;
          end else if (ch_i == CH_BSLASH) begin
            mode_d = M_ESCAPE;
          end else begin
            if (tbytes_d != 16'hFFFF) tbytes_d = tbytes_d + 16'd1;
            recs[n_rec] = mk_rec(REC_BYTE, ch_i, K_EOF, sline_d, scol_d, tbytes_d);
            n_rec = n_rec + 2'd1;
          end
        end
        M_ESCAPE: begin
          // Translate the escaped byte
          if (ch_i == CH_LOW_N) esc_byte = CH_NEWLINE;
          else if (ch_i == CH_LOW_T) esc_byte = CH_TAB;
          else if (ch_i == CH_LOW_R) esc_byte = CH_CR;
          if (ch_i == CH_NEWLINE) begin
            if (line_d != '1) line_d = line_d + 1'b1;
            col_d = POS_WIDTH'(1);
          end else if (col_d != '1) begin
            col_d = col_d + 1'b1;
          end
          if (tbytes_d != 16'hFFFF) tbytes_d = tbytes_d + 16'd1;
          recs[n_rec] = mk_rec(REC_BYTE, esc_byte, K_EOF, sline_d, scol_d, tbytes_d);
          n_rec = n_rec + 2'd1;
          mode_d = M_STRING;
        end
        default: begin
          do_idle = 1'b1;
        end
      endcase

      // Start a new token, or skip whitespace
      if (do_idle) begin
        mode_d = M_IDLE;
        if (is_space(ch_i)) begin
          if (ch_i == CH_NEWLINE) begin
            if (line_d != '1) line_d = line_d + 1'b1;
            col_d = POS_WIDTH'(1);
          end else if (col_d != '1) begin
            col_d = col_d + 1'b1;
          end
        end else begin
          sline_d  = line_d;
          scol_d   = col_d;
          tbytes_d = 16'h0001;
          pfx_d    = '0;
          wlen_d   = 4'd0;
          if (col_d != '1) col_d = col_d + 1'b1;
          recs[n_rec] = mk_rec(REC_BYTE, ch_i, K_EOF, sline_d, scol_d, tbytes_d);
          if (is_digit(ch_i)) begin
            mode_d = M_NUMBER;
            n_rec = n_rec + 2'd1;
          end else if (is_alpha(ch_i) || (ch_i == CH_UNDER)) begin
            mode_d = M_IDENT;
            pfx_d[7:0] = ch_i;
            wlen_d = 4'd1;
            n_rec = n_rec + 2'd1;
          end else if (ch_i == CH_QUOTE) begin
            mode_d = M_STRING;
            tbytes_d = 16'h0000;
          end else if (ch_i == CH_EQUALS) begin
            mode_d = M_ASSIGN;
            n_rec = n_rec + 2'd1;
          end else begin
            case (ch_i)
              CH_PLUS:   op_kind = K_PLUS;
              CH_MINUS:  op_kind = K_MINUS;
              CH_STAR:   op_kind = K_MULT;
              CH_SLASH:  op_kind = K_DIV;
              CH_LPAREN: op_kind = K_LPAREN;
              CH_RPAREN: op_kind = K_RPAREN;
              default:   op_kind = K_ERROR;
            endcase
            n_rec = n_rec + 2'd1;
            recs[n_rec] = mk_rec(REC_CLOSE, (op_kind == K_ERROR) ? ch_i : 8'h00, op_kind,
                                 sline_d, scol_d, tbytes_d);
            n_rec = n_rec + 2'd1;
          end
        end
      end
    end

    // Mark the final record of this word
    if (n_rec != 2'd0) recs[n_rec - 2'd1].last = 1'b1;
  end

  assign push_o.cnt  = accept_i ? n_rec : 2'd0;
  assign push_o.recs = recs;

  // Advance the scanner state on each accepted word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= M_IDLE;
      pfx_q    <= '0;
      wlen_q   <= 4'd0;
      tbytes_q <= 16'h0000;
      line_q   <= POS_WIDTH'(1);
      col_q    <= POS_WIDTH'(1);
      sline_q  <= POS_WIDTH'(1);
      scol_q   <= POS_WIDTH'(1);
    end else if (accept_i) begin
      mode_q   <= mode_d;
      pfx_q    <= pfx_d;
      wlen_q   <= wlen_d;
      tbytes_q <= tbytes_d;
      line_q   <= line_d;
      col_q    <= col_d;
      sline_q  <= sline_d;
      scol_q   <= scol_d;
    end
  end

endmodule

// ===== src/sts_queue.sv =====
// Four-entry result queue: takes up to three records in a cycle and hands out
// one word a cycle on pop. Depends on sts_pkg and the assertion macro header.
module sts_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sts_pkg::push_t     push_i,
  input  logic               pop_i,
  output logic               room_o,
  output logic               valid_o,
  output sts_pkg::rec_t      head_o
);
  import sts_pkg::*;
  `include "script_token_scanner_unit_assert.svh"

  rec_t           mem_q [QDEPTH];
  logic [QAW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QAW:0]   count_q, count_d;
  logic           do_pop;

  assign do_pop  = pop_i && (count_q != '0);
  assign count_d = count_q + (QAW+1)'(push_i.cnt) - (QAW+1)'(do_pop);
  assign room_o  = (count_q <= (QAW+1)'(QDEPTH - 3));
  assign valid_o = (count_q != '0);
  assign head_o  = mem_q[rd_ptr_q];

  // Store pushed records at the tail
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      if (2'(k) < push_i.cnt) mem_q[wr_ptr_q + QAW'(k)] <= push_i.recs[k];
    end
  end

  // Move pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QAW'(push_i.cnt);
      if (do_pop) rd_ptr_q <= rd_ptr_q + 1'b1;
      count_q  <= count_d;
    end
  end

  `STS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= (QAW+1)'(QDEPTH), "queue overfilled")
  `STS_ASSERT_IMPLY(a_push_room, clk_i, rst_ni, push_i.cnt != 2'd0, room_o, "push without room")
  `STS_ASSERT_IMPLY(a_ptr_gap, clk_i, rst_ni, count_q != (QAW+1)'(QDEPTH), count_q[QAW-1:0] == (wr_ptr_q - rd_ptr_q), "pointers disagree with count")
  `STS_ASSERT_IMPLY(a_empty_tail, clk_i, rst_ni, count_q == '0, wr_ptr_q == rd_ptr_q, "empty queue with pointer gap")

endmodule

// ===== src/script_token_scanner_unit.sv =====
// Top level of the token scanner unit: stream ports, scanner core and result
// queue. Depends on sts_pkg, sts_core and sts_queue.
//
//  channel  | dir | tdata                    | tuser         | tlast
//  ---------+-----+--------------------------+---------------+--------------
//  s_axis   | in  | ch                       | end_of_input  | -
//  m_axis   | out | lex_byte .. tok_length   | rec_kind      | last_of_run
//
// While m_axis_tready is high, the four-entry result queue drains one word a
// cycle and one source word is taken every cycle while each word yields at
// most one record; a word yielding two or three records holds s_axis_tready
// low until the queue holds at most one record. s_axis_tready depends only on
// the queue fill count, not on m_axis_tready. After reset the position is
// line 1, column 1 and the scanner is idle; no clearing pass is needed.
module script_token_scanner_unit #(
  parameter int POS_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] ch
  input  logic        s_axis_tuser,   // [0] end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // [7:0] lex_byte, [13:8] token_kind, [29:14] tok_line,
                                      // [45:30] tok_column, [61:46] tok_length, [63:62] zero
  output logic        m_axis_tuser,   // [0] rec_kind
  output logic        m_axis_tlast
);
  import sts_pkg::*;

  logic  accept;
  logic  room;
  push_t push;
  rec_t  head;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  sts_core #(
    .POS_WIDTH(POS_WIDTH)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .ch_i    (s_axis_tdata),
    .eoi_i   (s_axis_tuser),
    .push_o  (push)
  );

  sts_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (m_axis_tready),
    .room_o (room),
    .valid_o(m_axis_tvalid),
    .head_o (head)
  );

  // Pack the head record onto the output word
  assign m_axis_tdata = {2'b00, head.tok_length, head.tok_column, head.tok_line,
                         head.token_kind, head.lex_byte};
  assign m_axis_tuser = head.rec_kind;
  assign m_axis_tlast = head.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for script_token_scanner_unit: directed table and random source
// text, checked against a behavioural scanner model in tb; typed directed rows give
// their own final record. Depends on sts_pkg and the scanner RTL only.
module tb;
  import sts_pkg::*;

  localparam int unsigned RAND_WORDS    = 440;
  localparam int unsigned HOLD_AT       = 300;   // source word count that starts the hold-off
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned IDLE_LIMIT    = 3000;  // cycles with no word moving on either side
  localparam int unsigned DRAIN_CYCLES  = 16;
  localparam logic [5:0]  KIND_NONE     = 6'd0;  // token kind carried on byte records

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_NUMBER, SCAN_WORD, SCAN_STRING, SCAN_ESCAPE, SCAN_EQUALS
  } scan_mode_e;

  typedef struct packed {
    logic        rec_kind;
    logic [7:0]  lex_byte;
    logic [5:0]  token_kind;
    logic [15:0] tok_line;
    logic [15:0] tok_column;
    logic [15:0] tok_length;
    logic        last;
  } token_rec_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
    logic       typed;
    token_rec_t want;
  } dir_row_t;

  typedef struct {
    logic [7:0] ch;
    logic       eoi;
    bit         quiet;
    bit         typed;
    token_rec_t want;
  } src_word_t;

  localparam token_rec_t NO_REC = '0;

  // Directed source text; typed rows give the final record of their word
  localparam int DIR_ROWS = 27;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    '{8'h00, 1'b1, 1'b1, '{REC_CLOSE, 8'h00, K_EOF, 16'd1, 16'd1, 16'd0, 1'b1}},
    '{8'h40, 1'b0, 1'b1, '{REC_CLOSE, 8'h40, K_ERROR, 16'd1, 16'd1, 16'd1, 1'b1}},
    '{8'h00, 1'b0, 1'b1, '{REC_CLOSE, 8'h00, K_ERROR, 16'd1, 16'd2, 16'd1, 1'b1}},
    '{8'hFF, 1'b0, 1'b1, '{REC_CLOSE, 8'hFF, K_ERROR, 16'd1, 16'd3, 16'd1, 1'b1}},
    '{CH_DOT, 1'b0, 1'b1, '{REC_CLOSE, CH_DOT, K_ERROR, 16'd1, 16'd4, 16'd1, 1'b1}},
    '{CH_NEWLINE, 1'b0, 1'b0, NO_REC},
    '{8'h30, 1'b0, 1'b0, NO_REC},
    '{CH_DOT, 1'b0, 1'b0, NO_REC},
    '{CH_PLUS, 1'b0, 1'b0, NO_REC},
    '{CH_MINUS, 1'b0, 1'b0, NO_REC},
    '{CH_STAR, 1'b0, 1'b0, NO_REC},
    '{CH_SLASH, 1'b0, 1'b0, NO_REC},
    '{CH_LPAREN, 1'b0, 1'b0, NO_REC},
    '{CH_UNDER, 1'b0, 1'b0, NO_REC},
    '{8'h5A, 1'b0, 1'b0, NO_REC},
    '{CH_EQUALS, 1'b0, 1'b0, NO_REC},
    '{CH_EQUALS, 1'b0, 1'b0, NO_REC},
    '{CH_QUOTE, 1'b0, 1'b0, NO_REC},
    '{CH_BSLASH, 1'b0, 1'b0, NO_REC},
    '{CH_LOW_N, 1'b0, 1'b0, NO_REC},
    '{8'h80, 1'b0, 1'b0, NO_REC},
    '{CH_QUOTE, 1'b0, 1'b0, NO_REC},
    '{8'h69, 1'b0, 1'b0, NO_REC},
    '{8'h66, 1'b0, 1'b0, NO_REC},
    '{CH_RPAREN, 1'b0, 1'b0, NO_REC},
    '{CH_EQUALS, 1'b0, 1'b0, NO_REC},
    '{8'h00, 1'b1, 1'b0, NO_REC}
  };

  string kw_words [KEYWORD_COUNT] = '{
    "and", "break", "do", "else", "elseif", "end", "false", "for", "function", "if", "in",
    "local", "nil", "not", "or", "repeat", "return", "then", "true", "until", "while", "print"
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [63:0] m_axis_tdata;
  logic        m_axis_tuser;
  logic        m_axis_tlast;

  // Scanner model state
  scan_mode_e  sc_mode;
  logic [63:0] id_prefix;
  logic [3:0]  id_len;
  logic [15:0] lex_count;
  logic [15:0] pos_line;
  logic [15:0] pos_col;
  logic [15:0] tok_line0;
  logic [15:0] tok_col0;

  token_rec_t  step_recs [$];
  token_rec_t  pending_recs [$];
  src_word_t   stim_q [$];

  bit          offer_typed;
  token_rec_t  offer_want;
  bit          hold_req;
  bit          hold_active;
  int unsigned sent_words;
  int unsigned mismatches;
  int unsigned idle_cycles;

  script_token_scanner_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- scanner model

  function automatic bit is_num_char(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic bit is_letter(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_blank(input logic [7:0] c);
    return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic void reset_scanner();
    sc_mode   = SCAN_IDLE;
    id_prefix = '0;
    id_len    = '0;
    lex_count = '0;
    pos_line  = 16'd1;
    pos_col   = 16'd1;
    tok_line0 = 16'd1;
    tok_col0  = 16'd1;
  endfunction

  // Advance the position, holding line and column at their ceiling
  function automatic void move_pos(input logic [7:0] c);
    if (c == CH_NEWLINE) begin
      if (pos_line != 16'hFFFF) pos_line++;
      pos_col = 16'd1;
    end else if (pos_col != 16'hFFFF) begin
      pos_col++;
    end
  endfunction

  function automatic void put_rec(input logic rk, input logic [7:0] b, input logic [5:0] tk,
                                  input logic [15:0] ln, input logic [15:0] col,
                                  input logic [15:0] len);
    step_recs.push_back('{rk, b, tk, ln, col, len, 1'b0});
  endfunction

  function automatic void emit_lex(input logic [7:0] b);
    if (lex_count != 16'hFFFF) lex_count++;
    put_rec(REC_BYTE, b, KIND_NONE, tok_line0, tok_col0, lex_count);
  endfunction

  function automatic void put_close(input logic [5:0] tk, input logic [7:0] b);
    put_rec(REC_CLOSE, b, tk, tok_line0, tok_col0, lex_count);
  endfunction

  function automatic void open_token();
    tok_line0 = pos_line;
    tok_col0  = pos_col;
    lex_count = '0;
    id_prefix = '0;
    id_len    = '0;
  endfunction

  // Keep the first bytes of an identifier; the length stops one past the prefix
  function automatic void grow_word(input logic [7:0] c);
    if (id_len < 4'(KEYWORD_MAX_LEN)) id_prefix[8*id_len +: 8] = c;
    if (id_len <= 4'(KEYWORD_MAX_LEN)) id_len++;
  endfunction

  function automatic logic [5:0] word_kind();
    logic [63:0] kw_bits;
    if (id_len > 4'(KEYWORD_MAX_LEN)) return K_IDENT;
    for (int k = 0; k < KEYWORD_COUNT; k++) begin
      kw_bits = '0;
      for (int i = 0; i < kw_words[k].len() && i < KEYWORD_MAX_LEN; i++)
        kw_bits[8*i +: 8] = kw_words[k][i];
      if (kw_bits == id_prefix) return K_KEYWORD_BASE + 6'(k);
    end
    return K_IDENT;
  endfunction

  function automatic void close_token();
    case (sc_mode)
      SCAN_NUMBER:              put_close(K_NUMBER, 8'h00);
      SCAN_WORD:                put_close(word_kind(), 8'h00);
      SCAN_STRING, SCAN_ESCAPE: put_close(K_STRING, 8'h00);
      SCAN_EQUALS:              put_close(K_ASSIGN, 8'h00);
      default: ;
    endcase
    sc_mode = SCAN_IDLE;
  endfunction

  // Handle a byte with no token open
  function automatic void start_byte(input logic [7:0] c);
    logic [5:0] op;
    if (is_blank(c)) begin
      move_pos(c);
      return;
    end
    open_token();
    move_pos(c);
    if (is_num_char(c)) begin
      sc_mode = SCAN_NUMBER;
      emit_lex(c);
    end else if (is_letter(c) || c == CH_UNDER) begin
      sc_mode = SCAN_WORD;
      grow_word(c);
      emit_lex(c);
    end else if (c == CH_QUOTE) begin
      sc_mode = SCAN_STRING;
    end else if (c == CH_EQUALS) begin
      sc_mode = SCAN_EQUALS;
      emit_lex(c);
    end else begin
      case (c)
        CH_PLUS:   op = K_PLUS;
        CH_MINUS:  op = K_MINUS;
        CH_STAR:   op = K_MULT;
        CH_SLASH:  op = K_DIV;
        CH_LPAREN: op = K_LPAREN;
        CH_RPAREN: op = K_RPAREN;
        default:   op = K_ERROR;
      endcase
      emit_lex(c);
      put_close(op, (op == K_ERROR) ? c : 8'h00);
    end
  endfunction

  // Work out the records that one source word yields
  function automatic void scan_source_word(input logic [7:0] c, input logic eoi);
    logic [7:0] v;
    step_recs.delete();
    if (eoi) begin
      close_token();
      put_rec(REC_CLOSE, 8'h00, K_EOF, pos_line, pos_col, 16'd0);
    end else begin
      case (sc_mode)
        SCAN_NUMBER: begin
          if (is_num_char(c) || c == CH_DOT) begin
            move_pos(c);
            emit_lex(c);
          end else begin
            close_token();
            start_byte(c);
          end
        end
        SCAN_WORD: begin
          if (is_letter(c) || is_num_char(c) || c == CH_UNDER) begin
            move_pos(c);
            grow_word(c);
            emit_lex(c);
          end else begin
            close_token();
            start_byte(c);
          end
        end
        SCAN_EQUALS: begin
          if (c == CH_EQUALS) begin
            move_pos(c);
            emit_lex(c);
            put_close(K_EQ, 8'h00);
            sc_mode = SCAN_IDLE;
          end else begin
            close_token();
            start_byte(c);
          end
        end
        SCAN_STRING: begin
          move_pos(c);
          if (c == CH_QUOTE) begin
            put_close(K_STRING, 8'h00);
            sc_mode = SCAN_IDLE;
          end else if (c == CH_BSLASH) begin
            sc_mode = SCAN_ESCAPE;
          end else begin
            emit_lex(c);
          end
        end
        SCAN_ESCAPE: begin
          v = c;
          if (c == CH_LOW_N) v = CH_NEWLINE;
          else if (c == CH_LOW_T) v = CH_TAB;
          else if (c == CH_LOW_R) v = CH_CR;
          move_pos(c);
          emit_lex(v);
          sc_mode = SCAN_STRING;
        end
        default: start_byte(c);
      endcase
    end
    if (step_recs.size() != 0) step_recs[step_recs.size()-1].last = 1'b1;
  endfunction

  // ---------------------------------------------------------------- source text

  function automatic void queue_word(input logic [7:0] c, input logic eoi, input bit quiet);
    src_word_t w;
    w.ch    = c;
    w.eoi   = eoi;
    w.quiet = quiet;
    w.typed = 1'b0;
    w.want  = NO_REC;
    stim_q.push_back(w);
  endfunction

  function automatic logic [7:0] pick_letter();
    logic [7:0] c;
    c = 8'($urandom_range(8'h61, 8'h7A));
    if ($urandom_range(0, 3) == 0) c = c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'($urandom_range(8'h30, 8'h39));
  endfunction

  function automatic logic [7:0] pick_word_char();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 6) return pick_letter();
    if (r < 9) return pick_digit();
    return CH_UNDER;
  endfunction

  // Append one random fragment of script text, mostly well formed
  function automatic void gen_fragment();
    int unsigned sel, n, k;
    logic [7:0]  c;
    sel = $urandom_range(0, 99);
    if (sel < 16) begin
      // keyword, now and then stretched into a plain identifier
      k = $urandom_range(0, KEYWORD_COUNT - 1);
      for (int i = 0; i < kw_words[k].len(); i++) queue_word(kw_words[k][i], 1'b0, 1'b0);
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 4);
        repeat (n) queue_word(pick_word_char(), 1'b0, 1'b0);
      end
    end else if (sel < 30) begin
      n = $urandom_range(1, 12);
      queue_word(($urandom_range(0, 5) == 0) ? CH_UNDER : pick_letter(), 1'b0, 1'b0);
      repeat (n - 1) queue_word(pick_word_char(), 1'b0, 1'b0);
    end else if (sel < 41) begin
      queue_word(pick_digit(), 1'b0, 1'b0);
      n = $urandom_range(0, 5);
      repeat (n) queue_word(($urandom_range(0, 3) == 0) ? CH_DOT : pick_digit(), 1'b0, 1'b0);
    end else if (sel < 53) begin
      // quoted string with escapes, raw bytes and newlines; sometimes left open
      queue_word(CH_QUOTE, 1'b0, 1'b0);
      n = $urandom_range(0, 8);
      repeat (n) begin
        k = $urandom_range(0, 19);
        if (k < 3) begin
          queue_word(CH_BSLASH, 1'b0, 1'b0);
          case ($urandom_range(0, 5))
            0:       c = CH_LOW_N;
            1:       c = CH_LOW_T;
            2:       c = CH_LOW_R;
            3:       c = CH_QUOTE;
            4:       c = CH_BSLASH;
            default: c = 8'($urandom_range(0, 255));
          endcase
          queue_word(c, 1'b0, 1'b0);
        end else if (k == 3) begin
          queue_word(CH_NEWLINE, 1'b0, 1'b0);
        end else if (k < 6) begin
          queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end else begin
          queue_word(pick_letter(), 1'b0, 1'b0);
        end
      end
      if ($urandom_range(0, 9) != 0) queue_word(CH_QUOTE, 1'b0, 1'b0);
    end else if (sel < 67) begin
      case ($urandom_range(0, 7))
        0: queue_word(CH_PLUS, 1'b0, 1'b0);
        1: queue_word(CH_MINUS, 1'b0, 1'b0);
        2: queue_word(CH_STAR, 1'b0, 1'b0);
        3: queue_word(CH_SLASH, 1'b0, 1'b0);
        4: queue_word(CH_LPAREN, 1'b0, 1'b0);
        5: queue_word(CH_RPAREN, 1'b0, 1'b0);
        6: queue_word(CH_EQUALS, 1'b0, 1'b0);
        default: begin
          queue_word(CH_EQUALS, 1'b0, 1'b0);
          queue_word(CH_EQUALS, 1'b0, 1'b0);
        end
      endcase
    end else if (sel < 82) begin
      n = $urandom_range(1, 3);
      repeat (n) begin
        c = 8'($urandom_range(9, 14));
        queue_word((c == 8'd14) ? CH_SPACE : c, 1'b0, 1'b0);
      end
    end else if (sel < 91) begin
      queue_word(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end else if (sel < 94) begin
      queue_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end else begin
      // text cut short by end of input
      case ($urandom_range(0, 3))
        0: begin
          queue_word(CH_QUOTE, 1'b0, 1'b0);
          queue_word(pick_letter(), 1'b0, 1'b0);
          queue_word(CH_BSLASH, 1'b0, 1'b0);
        end
        1: queue_word(CH_EQUALS, 1'b0, 1'b0);
        2: begin
          queue_word(pick_letter(), 1'b0, 1'b0);
          queue_word(pick_word_char(), 1'b0, 1'b0);
        end
        default: begin
          queue_word(pick_digit(), 1'b0, 1'b0);
          queue_word(CH_DOT, 1'b0, 1'b0);
        end
      endcase
      queue_word(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
  endfunction

  // ---------------------------------------------------------------- checking

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, want, got);
    end
  endfunction

  function automatic void compare_rec(input token_rec_t want, input token_rec_t got);
    check_field("rec_kind", want.rec_kind, got.rec_kind);
    check_field("lex_byte", want.lex_byte, got.lex_byte);
    check_field("token_kind", want.token_kind, got.token_kind);
    check_field("tok_line", want.tok_line, got.tok_line);
    check_field("tok_column", want.tok_column, got.tok_column);
    check_field("tok_length", want.tok_length, got.tok_length);
    check_field("last_of_run", want.last, got.last);
  endfunction

  // Predict on each accepted source word, then check each accepted record
  always @(posedge clk_i) begin
    token_rec_t got;
    bit         moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        moved = 1'b1;
        scan_source_word(s_axis_tdata, s_axis_tuser);
        if (offer_typed && step_recs.size() != 0) step_recs[step_recs.size()-1] = offer_want;
        foreach (step_recs[i]) pending_recs.push_back(step_recs[i]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[13:8], m_axis_tdata[29:14],
                m_axis_tdata[45:30], m_axis_tdata[61:46], m_axis_tlast};
        if (pending_recs.size() == 0) begin
          mismatches++;
          $display("%0t: record with none expected: expected nothing, got %h", $time, got);
        end else begin
          compare_rec(pending_recs.pop_front(), got);
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
    end
  end

  // End the run when nothing moves for too long
  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) @(posedge clk_i);
    $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
    $display("FAIL script_token_scanner_unit");
    $finish;
  end

  // ---------------------------------------------------------------- result side

  // Stall on random runs; hold off once for a long stretch to fill the block
  initial begin
    bit          ready_state;
    int unsigned ready_run;
    ready_state   = 1'b0;
    ready_run     = 0;
    hold_active   = 1'b0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req      = 1'b0;
        hold_active   = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_active   = 1'b0;
        ready_run     = 0;
      end else begin
        if (ready_run == 0) begin
          ready_state = !ready_state;
          if (ready_state)
            ready_run = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200)
                                                     : $urandom_range(1, 20);
          else
            ready_run = $urandom_range(1, 6);
        end
        ready_run--;
        m_axis_tready <= ready_state;
      end
    end
  end

  // ---------------------------------------------------------------- source side

  initial begin
    src_word_t   w;
    int unsigned burst_left, gap, base;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    offer_typed   = 1'b0;
    offer_want    = NO_REC;
    hold_req      = 1'b0;
    sent_words    = 0;
    mismatches    = 0;
    reset_scanner();

    // Directed table first
    for (int i = 0; i < DIR_ROWS; i++) begin
      w.ch    = DIRECTED[i].ch;
      w.eoi   = DIRECTED[i].eoi;
      w.quiet = 1'b0;
      w.typed = DIRECTED[i].typed;
      w.want  = DIRECTED[i].want;
      stim_q.push_back(w);
    end
    // Random script text
    base = stim_q.size();
    while (stim_q.size() - base < RAND_WORDS) gen_fragment();
    queue_word(8'h00, 1'b1, 1'b0);

    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Offer words in bursts with random gaps between them
    burst_left = 0;
    while (stim_q.size() != 0) begin
      w = stim_q.pop_front();
      @(negedge clk_i);
      if (!w.quiet && !hold_active && burst_left == 0) begin
        burst_left = $urandom_range(1, 32);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          s_axis_tvalid <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      if (burst_left != 0) burst_left--;
      s_axis_tvalid <= 1'b1;
      s_axis_tdata  <= w.ch;
      s_axis_tuser  <= w.eoi;
      offer_typed   <= w.typed;
      offer_want    <= w.want;
      do @(posedge clk_i); while (!s_axis_tready);
      sent_words++;
      if (sent_words == HOLD_AT) hold_req = 1'b1;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;

    // Drain, then watch for stray records
    while (pending_recs.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && pending_recs.size() == 0)
      $display("PASS script_token_scanner_unit");
    else
      $display("FAIL script_token_scanner_unit");
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/sts_pkg.sv
src/sts_core.sv
src/sts_queue.sv
src/script_token_scanner_unit.sv
tb/tb.sv
